// File: sv/sstr_pkg.sv
// ----------------------------------------------------------------------------
// sstr_pkg
// Shared types, constants and helpers of the seven-segment text rasterizer.
// ----------------------------------------------------------------------------
package sstr_pkg;

    localparam int MAX_GLYPH_HEIGHT = 64;
    localparam int GH_W = 7;
    localparam int TH_W = 6;

    localparam logic [7:0] LEAD_BYTE  = 8'hC2;
    localparam logic [7:0] DEG_BYTE_A = 8'hB0;
    localparam logic [7:0] DEG_BYTE_B = 8'hBA;

    localparam logic [2:0] CFG_SCREEN_W = 3'd0;
    localparam logic [2:0] CFG_SCREEN_H = 3'd1;
    localparam logic [2:0] CFG_GLYPH_H  = 3'd2;
    localparam logic [2:0] CFG_STROKE   = 3'd3;
    localparam logic [2:0] CFG_LIT      = 3'd4;
    localparam logic [2:0] CFG_UNLIT    = 3'd5;

    // glyph class of the byte being drawn
    typedef enum logic [2:0] {
        GL_NONE,
        GL_DIGIT,
        GL_SPACE,
        GL_DOT,
        GL_COMMA,
        GL_COLON,
        GL_PLUS,
        GL_SLASH
    } glyph_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECT,
        ST_DIV,
        ST_CLIP,
        ST_OUT,
        ST_DONE
    } state_t;

    // raw rectangle before clipping
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [16:0] w;
        logic [16:0] h;
        logic [15:0] color;
        logic        valid;
    } rect_t;

    // seven-segment masks for 0..9 and minus
    function automatic logic [6:0] seg_mask(input logic [3:0] idx);
        logic [6:0] m;
        unique case (idx)
            4'd0: m = 7'h3F;
            4'd1: m = 7'h06;
            4'd2: m = 7'h5B;
            4'd3: m = 7'h4F;
            4'd4: m = 7'h66;
            4'd5: m = 7'h6D;
            4'd6: m = 7'h7D;
            4'd7: m = 7'h07;
            4'd8: m = 7'h7F;
            4'd9: m = 7'h6F;
            default: m = 7'h40;
        endcase
        return m;
    endfunction

endpackage

// File: sv/sstr_div.sv
// ----------------------------------------------------------------------------
// sstr_div
// Restoring divider, one quotient bit per cycle, for the slash row offsets.
// ----------------------------------------------------------------------------
module sstr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [12:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [12:0] quotient
);
    import sstr_pkg::*;

    logic [12:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  trial;

    always_comb
    begin
        trial     = {rem_reg[6:0], quo_reg[12]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 8'd0;
            cnt_next  = 4'd13;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[11:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[11:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = busy_reg && (cnt_reg == 4'd1);
    assign quotient = quo_next;

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !done)
        else $error("divider done while idle");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != 4'd0))
        else $error("divider count ran out");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

endmodule

// File: sv/seven_segment_text_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_text_rasterizer_unit
// Turns text bytes into clipped seven-segment style filled rectangles.
// ----------------------------------------------------------------------------
// Sequence: each candidate rectangle is built (ST_RECT), clipped (ST_CLIP)
//   and advanced (ST_OUT) after the byte is accepted in ST_IDLE and before
//   ST_DONE finishes it; a slash row first waits in ST_DIV for the divider.
// Throughput: one byte at a time, through the single clip unit and the
//   shared divider; output stalls hold the sequence back.
// Reset: configuration registers return to their defaults, cursor and row to 0.
module seven_segment_text_rasterizer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        text_start,
    input  logic [15:0] origin_x,
    input  logic [15:0] origin_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] rect_x,
    output logic [15:0] rect_y,
    output logic [15:0] rect_w,
    output logic [15:0] rect_h,
    output logic [15:0] rect_color,
    output logic        last_rect
);
    import sstr_pkg::*;

    logic [15:0] scr_w_reg, scr_h_reg, lit_reg, unlit_reg;
    logic [GH_W-1:0] gh_reg;
    logic [TH_W-1:0] th_reg;

    state_t state_reg, state_next;
    logic [15:0] col_reg, row_reg, x_reg;
    logic        lead_reg;
    glyph_t      gl_reg;
    logic [6:0]  mask_reg;
    logic [6:0]  idx_reg;
    logic [6:0]  hgt_reg;
    logic [5:0]  t_reg;
    logic [5:0]  w_reg;
    logic        bg_reg;
    logic        deg_reg;
    rect_t       cand_reg;
    logic        have_reg;
    logic [15:0] o_x_reg, o_y_reg, o_w_reg, o_h_reg, o_c_reg;
    logic        o_valid_reg, o_last_reg;
    logic        div_start, div_done;
    logic [12:0] div_q;

    // clamped sizes
    logic [6:0] hgt_c;
    logic [5:0] t_c, w_c;
    always_comb
    begin
        hgt_c = (gh_reg < 7'd6) ? 7'd6 :
                (gh_reg > 7'(MAX_GLYPH_HEIGHT)) ? 7'(MAX_GLYPH_HEIGHT) : gh_reg;
        t_c   = (th_reg == 6'd0) ? 6'd1 : (th_reg > 6'd32) ? 6'd32 : th_reg;
        w_c   = (hgt_c[6:1] < 6'd8) ? 6'd8 : hgt_c[6:1];
    end

    // ------------------------------------------------------------------
    // candidate rectangle for step idx_reg of the current glyph
    // ------------------------------------------------------------------
    rect_t cand;
    always_comb
    begin
        logic [15:0] x, y, t, h, w, dot, vlen, iw, ymid, size, dx, h3, h23;
        logic [15:0] xw;
        x    = x_reg;
        y    = row_reg;
        t    = 16'(t_reg);
        h    = 16'(hgt_reg);
        w    = 16'(w_reg);
        dot  = (t_reg < 6'd2) ? 16'd2 : t;
        vlen = (h > 16'd3 * t) ? ((h - 16'd3 * t) >> 1) : 16'd1;
        iw   = (w > 2 * t) ? (w - 16'd2 * t) : 16'd1;
        ymid = y + t + vlen;
        h3   = (16'(hgt_reg) * 16'd171) >> 9;
        h23  = (16'({hgt_reg, 1'b0}) * 16'd171) >> 9;
        size = (h3 < 16'd2 * t + 16'd2) ? (16'd2 * t + 16'd2) : h3;
        xw   = x + w;
        dx   = xw - size;
        cand = '0;
        cand.color = lit_reg;
        if (deg_reg)
        begin
            unique case (idx_reg[2:0])
                3'd0: begin cand = '{dx, y, 17'(size), 17'(size), unlit_reg, bg_reg}; end
                3'd1: begin cand = '{dx, y, 17'(size), 17'(t), lit_reg, 1'b1}; end
                3'd2: begin cand = '{dx, y + size - t, 17'(size), 17'(t), lit_reg, 1'b1}; end
                3'd3: begin cand = '{dx, y, 17'(t), 17'(size), lit_reg, 1'b1}; end
                3'd4: begin cand = '{dx + size - t, y, 17'(t), 17'(size), lit_reg, 1'b1}; end
                default: cand.valid = 1'b0;
            endcase
        end
        else
        begin
            unique case (gl_reg)
                GL_DIGIT:
                begin
                    unique case (idx_reg[2:0])
                        3'd0: cand = '{x, y, 17'(w), 17'(h), unlit_reg, bg_reg};
                        3'd1: cand = '{x + t, y, 17'(iw), 17'(t),
                                       mask_reg[0] ? lit_reg : unlit_reg, 1'b1};
                        3'd2: cand = '{xw - t, y + t, 17'(t), 17'(vlen),
                                       mask_reg[1] ? lit_reg : unlit_reg, 1'b1};
                        3'd3: cand = '{xw - t, ymid + t, 17'(t), 17'(vlen),
                                       mask_reg[2] ? lit_reg : unlit_reg, 1'b1};
                        3'd4: cand = '{x + t, y + h - t, 17'(iw), 17'(t),
                                       mask_reg[3] ? lit_reg : unlit_reg, 1'b1};
                        3'd5: cand = '{x, ymid + t, 17'(t), 17'(vlen),
                                       mask_reg[4] ? lit_reg : unlit_reg, 1'b1};
                        3'd6: cand = '{x, y + t, 17'(t), 17'(vlen),
                                       mask_reg[5] ? lit_reg : unlit_reg, 1'b1};
                        3'd7: cand = '{x + t, ymid, 17'(iw), 17'(t),
                                       mask_reg[6] ? lit_reg : unlit_reg, 1'b1};
                        default: cand.valid = 1'b0;
                    endcase
                end
                GL_SPACE:
                    if (idx_reg == 7'd0)
                        cand = '{x, y, 17'(w), 17'(h), unlit_reg, bg_reg};
                GL_DOT:
                    if (idx_reg == 7'd0)
                        cand = '{xw - dot, y + h - dot, 17'(dot), 17'(dot), lit_reg, 1'b1};
                GL_COMMA:
                begin
                    if (idx_reg == 7'd0)
                        cand = '{xw - dot, y + h - dot, 17'(dot), 17'(dot), lit_reg, 1'b1};
                    else if (idx_reg == 7'd1)
                        cand = '{xw - dot - (t >> 1), y + h, 17'(dot), 17'(t), lit_reg, 1'b1};
                end
                GL_COLON:
                begin
                    if (idx_reg == 7'd0)
                        cand = '{x + (w >> 1) - (dot >> 1), y + h3 - (dot >> 1),
                                 17'(dot), 17'(dot), lit_reg, 1'b1};
                    else if (idx_reg == 7'd1)
                        cand = '{x + (w >> 1) - (dot >> 1), y + h23 - (dot >> 1),
                                 17'(dot), 17'(dot), lit_reg, 1'b1};
                end
                GL_PLUS:
                begin
                    if (idx_reg == 7'd0)
                        cand = '{x + (w >> 1) - (t >> 1), y, 17'(t), 17'(h), lit_reg, 1'b1};
                    else if (idx_reg == 7'd1)
                        cand = '{x, y + (h >> 1) - (t >> 1), 17'(w), 17'(t), lit_reg, 1'b1};
                end
                // row offset comes straight from the divider on its last cycle
                GL_SLASH:
                    cand = '{x + 16'(div_q), y + 16'(idx_reg), 17'(t), 17'd1,
                             lit_reg, 1'b1};
                default: cand.valid = 1'b0;
            endcase
        end
    end

    // number of candidate steps for the glyph
    logic [6:0] steps;
    always_comb
    begin
        if (deg_reg)
            steps = 7'd5;
        else
        begin
            unique case (gl_reg)
                GL_DIGIT: steps = 7'd8;
                GL_SPACE: steps = 7'd1;
                GL_DOT:   steps = 7'd1;
                GL_COMMA: steps = 7'd2;
                GL_COLON: steps = 7'd2;
                GL_PLUS:  steps = 7'd2;
                GL_SLASH: steps = hgt_reg;
                default:  steps = 7'd0;
            endcase
        end
    end

    // clip the registered candidate
    logic        clip_ok;
    logic [15:0] clip_w, clip_h;
    always_comb
    begin
        logic [17:0] xe, ye;
        xe = 18'(cand_reg.x) + 18'(cand_reg.w);
        ye = 18'(cand_reg.y) + 18'(cand_reg.h);
        clip_ok = cand_reg.valid && (cand_reg.w != 17'd0) && (cand_reg.h != 17'd0)
                  && (cand_reg.x < scr_w_reg) && (cand_reg.y < scr_h_reg);
        clip_w = (xe > 18'(scr_w_reg)) ? (scr_w_reg - cand_reg.x) : cand_reg.w[15:0];
        clip_h = (ye > 18'(scr_h_reg)) ? (scr_h_reg - cand_reg.y) : cand_reg.h[15:0];
    end

    logic last_step;
    assign last_step = (idx_reg + 7'd1 >= steps);

    sstr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (13'(hgt_reg - 7'd1 - idx_reg) * 13'(w_reg)),
        .divisor  (hgt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_RECT;
            ST_RECT:
                if (idx_reg >= steps) state_next = ST_DONE;
                else if (gl_reg == GL_SLASH && !deg_reg) state_next = ST_DIV;
                else state_next = ST_CLIP;
            ST_DIV:  if (div_done) state_next = ST_CLIP;
            ST_CLIP: if (!o_valid_reg || !out_stall) state_next = ST_OUT;
            ST_OUT:  state_next = last_step ? ST_DONE : ST_RECT;
            ST_DONE: if (!o_valid_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_RECT) && (idx_reg < steps)
                    && (gl_reg == GL_SLASH) && !deg_reg;
    end

    // load the output word from the held rectangle
    logic load_out;
    assign load_out = (!o_valid_reg || !out_stall) && have_reg
                      && (((state_reg == ST_CLIP) && clip_ok) || (state_reg == ST_DONE));

    // decode of an accepted byte
    glyph_t      gl_dec;
    logic        deg_dec, lead_dec, adv_pre;
    logic [15:0] col_start;
    always_comb
    begin
        logic lead_in;
        logic is_deg;
        lead_in   = text_start ? 1'b0 : lead_reg;
        col_start = text_start ? origin_x : col_reg;
        is_deg    = (text_byte == DEG_BYTE_A) || (text_byte == DEG_BYTE_B);
        adv_pre   = lead_in && !is_deg;
        lead_dec  = (text_byte == LEAD_BYTE);
        deg_dec   = is_deg;
        priority if (text_byte >= 8'h30 && text_byte <= 8'h39) gl_dec = GL_DIGIT;
        else if (text_byte == 8'h2D) gl_dec = GL_DIGIT;
        else if (text_byte == 8'h20) gl_dec = GL_SPACE;
        else if (text_byte == 8'h2E) gl_dec = GL_DOT;
        else if (text_byte == 8'h2C) gl_dec = GL_COMMA;
        else if (text_byte == 8'h3A) gl_dec = GL_COLON;
        else if (text_byte == 8'h2B) gl_dec = GL_PLUS;
        else if (text_byte == 8'h2F) gl_dec = GL_SLASH;
        else gl_dec = GL_NONE;
    end

    logic [15:0] adv_amt;
    assign adv_amt = 16'(w_c) + 16'(t_c) + 16'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scr_w_reg   <= 16'd170;
            scr_h_reg   <= 16'd320;
            gh_reg      <= 7'd32;
            th_reg      <= 6'd4;
            lit_reg     <= 16'hFFFF;
            unlit_reg   <= 16'h0000;
            col_reg     <= 16'd0;
            row_reg     <= 16'd0;
            lead_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
            idx_reg     <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SCREEN_W: scr_w_reg <= cfg_data;
                    CFG_SCREEN_H: scr_h_reg <= cfg_data;
                    CFG_GLYPH_H:  gh_reg    <= cfg_data[GH_W-1:0];
                    CFG_STROKE:   th_reg    <= cfg_data[TH_W-1:0];
                    CFG_LIT:      lit_reg   <= cfg_data;
                    CFG_UNLIT:    unlit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out)
                o_valid_reg <= 1'b1;
            else if (o_valid_reg && !out_stall)
                o_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        logic [15:0] c;
                        c = adv_pre ? (col_start + adv_amt) : col_start;
                        if (text_start)
                            row_reg <= origin_y;
                        idx_reg <= 7'd0;
                        have_reg <= 1'b0;
                        if (lead_dec)
                        begin
                            lead_reg <= 1'b1;
                            col_reg  <= c;
                        end
                        else
                        begin
                            lead_reg <= 1'b0;
                            col_reg  <= c + adv_amt;
                        end
                        x_reg <= c;
                    end
                ST_CLIP:
                    if (!o_valid_reg || !out_stall)
                    begin
                        // hold back one accepted rectangle so the last can be marked
                        if (clip_ok)
                            have_reg <= 1'b1;
                    end
                ST_OUT: idx_reg <= idx_reg + 7'd1;
                ST_DONE:
                    if ((!o_valid_reg || !out_stall) && have_reg)
                        have_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    logic [15:0] h_x_reg, h_y_reg, h_w_reg, h_h_reg, h_c_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            gl_reg   <= lead_dec ? GL_NONE : gl_dec;
            deg_reg  <= deg_dec && !lead_dec;
            mask_reg <= seg_mask((text_byte == 8'h2D) ? 4'd10 : text_byte[3:0]);
            hgt_reg  <= hgt_c;
            t_reg    <= t_c;
            w_reg    <= w_c;
            bg_reg   <= (lit_reg != unlit_reg);
        end
        if (state_reg == ST_RECT || (state_reg == ST_DIV && div_done))
            cand_reg <= cand;
        if (state_reg == ST_CLIP && (!o_valid_reg || !out_stall))
        begin
            if (clip_ok)
            begin
                h_x_reg <= cand_reg.x;
                h_y_reg <= cand_reg.y;
                h_w_reg <= clip_w;
                h_h_reg <= clip_h;
                h_c_reg <= cand_reg.color;
                if (have_reg)
                begin
                    o_x_reg <= h_x_reg;
                    o_y_reg <= h_y_reg;
                    o_w_reg <= h_w_reg;
                    o_h_reg <= h_h_reg;
                    o_c_reg <= h_c_reg;
                    o_last_reg <= 1'b0;
                end
            end
        end
        if (state_reg == ST_DONE && (!o_valid_reg || !out_stall) && have_reg)
        begin
            o_x_reg <= h_x_reg;
            o_y_reg <= h_y_reg;
            o_w_reg <= h_w_reg;
            o_h_reg <= h_h_reg;
            o_c_reg <= h_c_reg;
            o_last_reg <= 1'b1;
        end
    end

    assign out_valid  = o_valid_reg;
    assign rect_x     = o_x_reg;
    assign rect_y     = o_y_reg;
    assign rect_w     = o_w_reg;
    assign rect_h     = o_h_reg;
    assign rect_color = o_c_reg;
    assign last_rect  = o_last_reg;

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output word dropped under stall");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == ST_IDLE))
        else $error("config open while busy");

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives text bytes and register writes into the seven-segment rasterizer,
// predicts every clipped rectangle and checks each output word in order.
// ----------------------------------------------------------------------------
import sstr_pkg::*;

typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
    logic        last;
} rect_word_t;

class rect_scoreboard;
    logic [15:0] scr_w, scr_h, lit, unlit;
    logic [6:0]  gh_reg;
    logic [5:0]  th_reg;
    logic [15:0] col, row;
    bit          lead;
    rect_word_t  rect_q[$];
    int          n_bytes, n_rects, errors;
    rect_word_t  tmp_q[$];

    function new();
        scr_w = 170; scr_h = 320; gh_reg = 32; th_reg = 4;
        lit = 16'hFFFF; unlit = 0; col = 0; row = 0; lead = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
        case (idx)
            CFG_SCREEN_W: scr_w = d;
            CFG_SCREEN_H: scr_h = d;
            CFG_GLYPH_H:  gh_reg = d[6:0];
            CFG_STROKE:   th_reg = d[5:0];
            CFG_LIT:      lit = d;
            CFG_UNLIT:    unlit = d;
            default: ;
        endcase
    endfunction

    function void put(logic [15:0] x, logic [15:0] y, int unsigned w, int unsigned h,
                      logic [15:0] c);
        rect_word_t r;
        if (w == 0 || h == 0) return;
        if (x >= scr_w || y >= scr_h) return;
        if (x + w > scr_w) w = 32'(scr_w - x);
        if (y + h > scr_h) h = 32'(scr_h - y);
        if (tmp_q.size() >= 64) return;
        r.x = x; r.y = y; r.w = w[15:0]; r.h = h[15:0]; r.color = c; r.last = 0;
        tmp_q.push_back(r);
    endfunction

    function void draw(logic [7:0] ch, int unsigned hg, int unsigned t, int unsigned w);
        logic [15:0] x, y, ymid, cx, dx;
        bit bg;
        int unsigned dot, vlen, iw, pos, sz;
        logic [6:0] m;
        x = col; y = row; bg = (unlit != lit);
        dot = (t < 2) ? 2 : t;
        if ((ch >= "0" && ch <= "9") || ch == "-") begin
            m = (ch == "-") ? 7'h40 : seg_mask(4'(ch - "0"));
            vlen = (hg > 3 * t) ? (hg - 3 * t) / 2 : 1;
            iw = (w > 2 * t) ? w - 2 * t : 1;
            ymid = 16'(y + t + vlen);
            if (bg) put(x, y, w, hg, unlit);
            put(16'(x + t), y, iw, t, m[0] ? lit : unlit);
            put(16'(x + w - t), 16'(y + t), t, vlen, m[1] ? lit : unlit);
            put(16'(x + w - t), 16'(ymid + t), t, vlen, m[2] ? lit : unlit);
            put(16'(x + t), 16'(y + hg - t), iw, t, m[3] ? lit : unlit);
            put(x, 16'(ymid + t), t, vlen, m[4] ? lit : unlit);
            put(x, 16'(y + t), t, vlen, m[5] ? lit : unlit);
            put(16'(x + t), ymid, iw, t, m[6] ? lit : unlit);
            return;
        end
        case (ch)
            " ": if (bg) put(x, y, w, hg, unlit);
            ".": put(16'(x + w - dot), 16'(y + hg - dot), dot, dot, lit);
            ",": begin
                put(16'(x + w - dot), 16'(y + hg - dot), dot, dot, lit);
                put(16'(x + w - dot - t / 2), 16'(y + hg), dot, t, lit);
            end
            ":": begin
                cx = 16'(x + w / 2 - dot / 2);
                put(cx, 16'(y + hg / 3 - dot / 2), dot, dot, lit);
                put(cx, 16'(y + (2 * hg) / 3 - dot / 2), dot, dot, lit);
            end
            "+": begin
                put(16'(x + w / 2 - t / 2), y, t, hg, lit);
                put(x, 16'(y + hg / 2 - t / 2), w, t, lit);
            end
            "/": for (int unsigned i = 0; i < hg; i++) begin
                pos = ((hg - 1 - i) * w) / hg;
                put(16'(x + pos), 16'(y + i), t, 1, lit);
            end
            DEG_BYTE_A, DEG_BYTE_B: begin
                sz = hg / 3;
                if (sz < 2 * t + 2) sz = 2 * t + 2;
                dx = 16'(x + w - sz);
                if (bg) put(dx, y, sz, sz, unlit);
                put(dx, y, sz, t, lit);
                put(dx, 16'(y + sz - t), sz, t, lit);
                put(dx, y, t, sz, lit);
                put(16'(dx + sz - t), y, t, sz, lit);
            end
            default: ;
        endcase
    endfunction

    // note an accepted byte: compute its rectangles and queue them
    function void note_byte(logic [7:0] ch, bit st, logic [15:0] ox, logic [15:0] oy);
        int unsigned hg, t, w, adv;
        bit done;
        hg = 32'(gh_reg); t = 32'(th_reg);
        if (hg < 6) hg = 6;
        if (hg > MAX_GLYPH_HEIGHT) hg = MAX_GLYPH_HEIGHT;
        if (t < 1) t = 1;
        if (t > 32) t = 32;
        w = hg / 2;
        if (w < 8) w = 8;
        adv = w + t + 2;
        tmp_q.delete();
        done = 0;
        n_bytes++;
        if (st) begin
            col = ox; row = oy; lead = 0;
        end
        if (lead) begin
            lead = 0;
            if (ch == DEG_BYTE_A || ch == DEG_BYTE_B) begin
                draw(ch, hg, t, w);
                col = 16'(col + adv);
                done = 1;
            end else
                col = 16'(col + adv);
        end
        if (!done) begin
            if (ch == LEAD_BYTE) lead = 1;
            else begin
                draw(ch, hg, t, w);
                col = 16'(col + adv);
            end
        end
        if (tmp_q.size() > 0) tmp_q[tmp_q.size() - 1].last = 1;
        foreach (tmp_q[i]) rect_q.push_back(tmp_q[i]);
    endfunction

    function bit check_rect(rect_word_t got, output string msg);
        rect_word_t e;
        n_rects++;
        if (rect_q.size() == 0) begin
            msg = $sformatf("unexpected rect %h", got);
            return 0;
        end
        e = rect_q.pop_front();
        if (got !== e) begin
            msg = $sformatf({"rect mismatch got x%0d y%0d w%0d h%0d c%h l%0d",
                             " exp x%0d y%0d w%0d h%0d c%h l%0d"},
                got.x, got.y, got.w, got.h, got.color, got.last,
                e.x, e.y, e.w, e.h, e.color, e.last);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb;
    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [7:0]  text_byte;
    logic        text_start;
    logic [15:0] origin_x, origin_y;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        out_valid, out_stall;
    logic [15:0] rect_x, rect_y, rect_w, rect_h, rect_color;
    logic        last_rect;

    rect_scoreboard sb;
    int  fail_count;
    int  send_idle, recv_idle;
    int  hold_off;
    bit  hold_req, hold_ack;

    seven_segment_text_rasterizer_unit uut (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    task automatic report(string msg);
        $display("ERROR %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic send_byte(logic [7:0] b, bit st, logic [15:0] ox, logic [15:0] oy);
        while ($urandom_range(99) < send_idle) @(posedge clk);
        in_valid   <= 1;
        text_byte  <= b;
        text_start <= st;
        origin_x   <= ox;
        origin_y   <= oy;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(b, st, ox, oy);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        while (sb.rect_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic rand_byte();
        logic [7:0] b;
        int k;
        k = $urandom_range(99);
        if (k < 50) b = 8'("0" + $urandom_range(9));
        else if (k < 58) b = "-";
        else if (k < 75) begin
            case ($urandom_range(5))
                0: b = " "; 1: b = "."; 2: b = ","; 3: b = ":"; 4: b = "+";
                default: b = (sb.gh_reg <= 16) ? "/" : ".";
            endcase
        end else if (k < 82) b = LEAD_BYTE;
        else if (k < 90) b = $urandom_range(1) ? DEG_BYTE_A : DEG_BYTE_B;
        else b = 8'($urandom_range(255));
        if (b == "/" && sb.gh_reg > 16) b = "+";
        send_byte(b, $urandom_range(15) == 0, 16'($urandom_range(65535) % 300),
                  16'($urandom_range(7) == 0 ? $urandom : $urandom_range(330)));
    endtask

    task automatic rand_cfg();
        write_cfg(CFG_SCREEN_W,
                  16'($urandom_range(3) == 0 ? $urandom : 100 + $urandom_range(200)));
        write_cfg(CFG_SCREEN_H,
                  16'($urandom_range(3) == 0 ? $urandom : 100 + $urandom_range(250)));
        write_cfg(CFG_GLYPH_H, 16'($urandom_range(127)));
        write_cfg(CFG_STROKE, 16'($urandom_range(63)));
        write_cfg(CFG_LIT, 16'($urandom));
        write_cfg(CFG_UNLIT, $urandom_range(3) == 0 ? sb.lit : 16'($urandom));
    endtask

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_stall <= 1;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= 400;
            out_stall <= 1;
        end else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        string msg;
        if (rst_n && out_valid && !out_stall)
            if (!sb.check_rect({rect_x, rect_y, rect_w, rect_h, rect_color, last_rect}, msg))
                report(msg);
    end

    initial begin
        #50_000_000;
        $display("FAIL seven_segment_text_rasterizer_unit");
        $finish;
    end

    initial begin
        sb = new();
        fail_count = 0; send_idle = 0; recv_idle = 0; hold_req = 0;
        rst_n = 0; in_valid = 0; text_byte = 0; text_start = 0;
        origin_x = 0; origin_y = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset registers, every glyph, lead handling, clipping
        send_byte("8", 1, 0, 0);
        send_byte("-", 0, 0, 0);
        send_byte(" ", 0, 0, 0);
        send_byte(".", 0, 0, 0);
        send_byte(",", 0, 0, 0);
        send_byte(":", 0, 0, 0);
        send_byte("+", 0, 0, 0);
        send_byte(DEG_BYTE_A, 0, 0, 0);
        send_byte(LEAD_BYTE, 0, 0, 0);
        send_byte(DEG_BYTE_B, 0, 0, 0);
        send_byte(LEAD_BYTE, 0, 0, 0);
        send_byte(LEAD_BYTE, 0, 0, 0);
        send_byte("1", 0, 0, 0);
        send_byte(LEAD_BYTE, 0, 0, 0);
        send_byte("7", 1, 16'd150, 16'd300);
        send_byte(8'h00, 0, 0, 0);
        send_byte(8'hFF, 1, 16'hFFFF, 16'hFFFF);
        send_byte("0", 1, 16'd200, 0);
        wait_drain();
        write_cfg(CFG_SCREEN_W, 16'hFFFF);
        write_cfg(CFG_SCREEN_H, 16'hFFFF);
        write_cfg(CFG_GLYPH_H, 16'd6);
        write_cfg(CFG_STROKE, 16'd0);
        write_cfg(CFG_LIT, 16'h1234);
        write_cfg(CFG_UNLIT, 16'h1234);
        send_byte("/", 1, 16'hFFF0, 16'hFFF8);
        send_byte("4", 0, 0, 0);
        send_byte(" ", 0, 0, 0);
        wait_drain();
        write_cfg(CFG_GLYPH_H, 16'd127);
        write_cfg(CFG_STROKE, 16'd63);
        write_cfg(CFG_UNLIT, 16'h0000);
        send_byte("/", 1, 0, 0);
        send_byte("9", 0, 0, 0);
        wait_drain();

        // random phases: receiver-heavy idle, sender-heavy idle, none
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 27 : (ph == 1) ? 56 : 0;
            recv_idle = (ph == 0) ? 56 : (ph == 1) ? 27 : 0;
            for (int blk = 0; blk < 5; blk++) begin
                rand_cfg();
                if (blk == 2) hold_req = !hold_req;
                for (int i = 0; i < 30; i++) rand_byte();
                wait_drain();
            end
        end

        wait_drain();
        $display("Covered %0d text bytes and %0d rectangles over several register settings.",
                 sb.n_bytes, sb.n_rects);
        if (sb.rect_q.size() != 0) report("rectangles still expected at end");
        if (fail_count == 0)
            $display("PASS seven_segment_text_rasterizer_unit");
        else
            $display("FAIL seven_segment_text_rasterizer_unit");
        $finish;
    end
endmodule

// File: files.f
sv/sstr_pkg.sv
sv/sstr_div.sv
sv/seven_segment_text_rasterizer_unit.sv
tb/tb.sv
